FILE: rtl/core/dnsqfab_pkg.sv
// Package: shared constants, types and the reply byte table of the DNS answer builder.
`timescale 1ns / 1ps

package dnsqfab_pkg;

  localparam int unsigned MAX_QUERY_BYTES = 256;
  localparam int unsigned POS_W = $clog2(MAX_QUERY_BYTES + 1);

  localparam int unsigned HDR_LEN = 12;
  localparam int unsigned REC_LEN = 16;
  localparam int unsigned SEQ_LEN = HDR_LEN + REC_LEN;
  localparam int unsigned SEQ_W = $clog2(SEQ_LEN);

  typedef logic [SEQ_W-1:0] seq_idx_t;
  typedef logic [3:0][7:0] hdr_hold_t;

  localparam seq_idx_t SEQ_HDR_FIRST = SEQ_W'(0);
  localparam seq_idx_t SEQ_HDR_LAST = SEQ_W'(HDR_LEN - 1);
  localparam seq_idx_t SEQ_REC_FIRST = SEQ_W'(HDR_LEN);
  localparam seq_idx_t SEQ_REC_LAST = SEQ_W'(SEQ_LEN - 1);

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_ANSWER_IPV4 = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_RESPOND_EN = CFG_IDX_W'(1);

  localparam logic [31:0] ANSWER_IPV4_RST = 32'hC0A8_0401;

  localparam logic [7:0] FLAGS_HI = 8'h81;
  localparam logic [7:0] FLAGS_LO = 8'h80;
  localparam logic [7:0] NAME_PTR_HI = 8'hC0;
  localparam logic [7:0] NAME_PTR_LO = 8'h0C;
  localparam logic [7:0] TTL_LO = 8'h3C;
  localparam logic [7:0] RDLEN_LO = 8'h04;
  localparam logic [7:0] ONE_LO = 8'h01;

  // Header (indexes 0..11) followed by the A record (indexes 12..27).
  function automatic logic [7:0] seq_byte(input seq_idx_t idx, input hdr_hold_t hold,
                                          input logic [31:0] ipv4);
    logic [7:0] b;
    b = 8'h00;
    case (idx)
      SEQ_W'(0):  b = hold[0];
      SEQ_W'(1):  b = hold[1];
      SEQ_W'(2):  b = FLAGS_HI;
      SEQ_W'(3):  b = FLAGS_LO;
      SEQ_W'(4):  b = hold[2];
      SEQ_W'(5):  b = hold[3];
      SEQ_W'(7):  b = ONE_LO;      // answer count
      SEQ_W'(12): b = NAME_PTR_HI;
      SEQ_W'(13): b = NAME_PTR_LO;
      SEQ_W'(15): b = ONE_LO;      // type A
      SEQ_W'(17): b = ONE_LO;      // class IN
      SEQ_W'(21): b = TTL_LO;
      SEQ_W'(23): b = RDLEN_LO;
      SEQ_W'(24): b = ipv4[31:24];
      SEQ_W'(25): b = ipv4[23:16];
      SEQ_W'(26): b = ipv4[15:8];
      SEQ_W'(27): b = ipv4[7:0];
      default:    b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

FILE: rtl/core/dns_query_fixed_answer_builder.sv
// Top level: streaming DNS query in, captive-portal A-record reply out.
//
// Query bytes enter on query_* (valid/ready, query_last_i on the final byte);
// reply bytes leave on reply_* from an output register, reply_last_o on the
// final record byte. Register writes go through cfg_* (index 0: answer IPv4,
// index 1: respond enable); cfg_ready_o is always high.
// A reply byte is loaded into the output register as its query byte is taken.
// Throughput: one query byte per cycle while bytes are only echoed and the
// output is not stalled. At byte 11 the 12-byte header and at the last byte
// the 16-byte record (both if that is byte 11) go out one per cycle from a
// burst counter unless stalled; query_ready_o is low until the burst drains.
// Runt queries (under 12 bytes) and queries while disabled give no output.
// The enable is sampled on byte 0 of each query.
// Reset clears position, burst and output valid; the IPv4 register resets to
// 192.168.4.1 and the enable to 0. No clearing pass is needed.
// When reply_ready_i is low the output register holds and query_ready_o drops.
`timescale 1ns / 1ps

module dns_query_fixed_answer_builder (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                query_valid_i,
  output logic                                query_ready_o,
  input  logic [7:0]                          query_byte_i,
  input  logic                                query_last_i,
  output logic                                reply_valid_o,
  input  logic                                reply_ready_i,
  output logic [7:0]                          reply_byte_o,
  output logic                                reply_last_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [dnsqfab_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [31:0]                         cfg_data_i
);

  localparam int unsigned PW = dnsqfab_pkg::POS_W;
  localparam logic [PW-1:0] POS_MAX = PW'(dnsqfab_pkg::MAX_QUERY_BYTES);
  localparam logic [PW-1:0] POS_HDR_END = PW'(dnsqfab_pkg::HDR_LEN - 1);
  localparam logic [PW-1:0] POS_BODY = PW'(dnsqfab_pkg::HDR_LEN);

  logic [31:0]                ipv4_q;
  logic                       resp_en_q;
  logic [PW-1:0]              pos_q, pos_d;
  logic                       pkt_en_q;
  dnsqfab_pkg::hdr_hold_t     hold_q;
  logic                       burst_q, burst_d;
  dnsqfab_pkg::seq_idx_t      idx_q, idx_d;
  dnsqfab_pkg::seq_idx_t      end_q, end_d;
  logic                       out_valid_q, out_valid_d;
  logic [7:0]                 out_byte_q, out_byte_d;
  logic                       out_last_q, out_last_d;

  logic                       load_ok, q_acc, en_now;
  logic                       do_echo, do_hdr, do_rec;
  dnsqfab_pkg::seq_idx_t      start_idx;

  assign cfg_ready_o   = 1'b1;
  assign load_ok       = !out_valid_q || reply_ready_i;
  assign query_ready_o = load_ok && !burst_q;
  assign q_acc         = query_valid_i && query_ready_o;

  assign reply_valid_o = out_valid_q;
  assign reply_byte_o  = out_byte_q;
  assign reply_last_o  = out_last_q;

  assign en_now  = (pos_q == '0) ? resp_en_q : pkt_en_q;
  assign do_echo = en_now && (pos_q >= POS_BODY) && (pos_q < POS_MAX);
  assign do_hdr  = en_now && (pos_q == POS_HDR_END);
  assign do_rec  = en_now && query_last_i && (pos_q >= POS_HDR_END);
  assign start_idx = do_hdr ? dnsqfab_pkg::SEQ_HDR_FIRST : dnsqfab_pkg::SEQ_REC_FIRST;

  always_comb begin
    pos_d       = pos_q;
    burst_d     = burst_q;
    idx_d       = idx_q;
    end_d       = end_q;
    out_valid_d = out_valid_q;
    out_byte_d  = out_byte_q;
    out_last_d  = out_last_q;
    if (load_ok) begin
      out_valid_d = 1'b0;
    end
    if (q_acc) begin
      if (query_last_i) begin
        pos_d = '0;
      end else if (pos_q < POS_MAX) begin
        pos_d = pos_q + PW'(1);
      end
      end_d = do_rec ? dnsqfab_pkg::SEQ_REC_LAST : dnsqfab_pkg::SEQ_HDR_LAST;
      if (do_echo) begin
        out_valid_d = 1'b1;
        out_byte_d  = query_byte_i;
        out_last_d  = 1'b0;
        burst_d     = do_rec;
        idx_d       = dnsqfab_pkg::SEQ_REC_FIRST;
      end else if (do_hdr || do_rec) begin
        out_valid_d = 1'b1;
        out_byte_d  = dnsqfab_pkg::seq_byte(start_idx, hold_q, ipv4_q);
        out_last_d  = 1'b0;
        burst_d     = 1'b1;
        idx_d       = start_idx + dnsqfab_pkg::SEQ_W'(1);
      end
    end else if (burst_q && load_ok) begin
      out_valid_d = 1'b1;
      out_byte_d  = dnsqfab_pkg::seq_byte(idx_q, hold_q, ipv4_q);
      out_last_d  = (idx_q == dnsqfab_pkg::SEQ_REC_LAST);
      if (idx_q == end_q) begin
        burst_d = 1'b0;
      end else begin
        idx_d = idx_q + dnsqfab_pkg::SEQ_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ipv4_q      <= dnsqfab_pkg::ANSWER_IPV4_RST;
      resp_en_q   <= 1'b0;
      pos_q       <= '0;
      pkt_en_q    <= 1'b0;
      burst_q     <= 1'b0;
      idx_q       <= '0;
      end_q       <= '0;
      out_valid_q <= 1'b0;
      out_last_q  <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        if (cfg_index_i == dnsqfab_pkg::CFG_ANSWER_IPV4) begin
          ipv4_q <= cfg_data_i;
        end else if (cfg_index_i == dnsqfab_pkg::CFG_RESPOND_EN) begin
          resp_en_q <= cfg_data_i[0];
        end
      end
      if (q_acc && pos_q == '0) begin
        pkt_en_q <= resp_en_q;
      end
      pos_q       <= pos_d;
      burst_q     <= burst_d;
      idx_q       <= idx_d;
      end_q       <= end_d;
      out_valid_q <= out_valid_d;
      out_last_q  <= out_last_d;
    end
  end

  // Payload registers: ID and question-count bytes, reply byte
  always_ff @(posedge clk_i) begin
    out_byte_q <= out_byte_d;
    if (q_acc) begin
      if (pos_q == PW'(0)) hold_q[0] <= query_byte_i;
      if (pos_q == PW'(1)) hold_q[1] <= query_byte_i;
      if (pos_q == PW'(4)) hold_q[2] <= query_byte_i;
      if (pos_q == PW'(5)) hold_q[3] <= query_byte_i;
    end
  end

  // A burst always has a byte sitting in the output register.
  a_burst_has_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    burst_q |-> out_valid_q)
    else $error("burst active without a pending reply byte");

  // The final record byte closes the burst.
  a_last_ends_burst: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_last_q) |-> !burst_q)
    else $error("reply_last while burst still active");

  a_idx_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    burst_q |-> (idx_q <= end_q))
    else $error("burst index past its end");

  a_end_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    burst_q |-> (end_q == dnsqfab_pkg::SEQ_HDR_LAST || end_q == dnsqfab_pkg::SEQ_REC_LAST))
    else $error("burst end is neither header nor record end");

endmodule
